[rtl/tcc_pkg.sv]
// Shared types and constants for the text console cursor engine.
`timescale 1ns / 1ps

package tcc_pkg;

    localparam int COL_W  = 8;
    localparam int ROW_W  = 7;
    localparam int CHAR_W = 8;
    localparam int CNT_W  = 8;
    localparam int FUNC_W = 3;

    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 8;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 48;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;

    localparam logic [CFG_ADDR_W-1:0] CFG_FG_COLOR = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BG_COLOR = 8'd1;

    localparam logic [CFG_DATA_W-1:0] FG_COLOR_RESET = 8'd3;
    localparam logic [CFG_DATA_W-1:0] BG_COLOR_RESET = 8'd0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUT_CHAR  = 3'd0,
        FUNC_SET_CUR   = 3'd1,
        FUNC_BACKWARD  = 3'd2,
        FUNC_READ_CELL = 3'd3,
        FUNC_CLEAR     = 3'd4
    } func_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_WRITE,
        ST_SCROLL,
        ST_SCROLL_END,
        ST_BACK,
        ST_RD,
        ST_RDCAP,
        ST_DONE
    } state_t;

endpackage

[rtl/text_console_cursor_engine.sv]
// Top level of the text console cursor engine: command sequencer around the character store.
//
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid / s_tready  | tuser: func; tdata: char_code, col, row, count
//  m_      | out | m_tvalid / m_tready  | tuser: draw_valid; tdata: draw and cursor fields
//  cfg_    | in  | cfg_valid / cfg_ready| cfg_addr, cfg_wdata (colors)
//
// A drawn char passes ST_EXEC, ST_WRITE and ST_DONE; an in-range read cell ST_EXEC,
// ST_RD, ST_RDCAP and ST_DONE; any other request ST_EXEC and ST_DONE. Backward steps
// the cursor in ST_BACK, one step per cycle, count steps in all. A scroll moves one
// store entry per cycle on the single write port. After reset a clearing pass zeroes
// all COLUMNS*ROWS cells of the store; s_tready stays low during it, cfg requests are taken.
// A finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps

module text_console_cursor_engine #(
    parameter int COLUMNS = tcc_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcc_pkg::DEF_ROWS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [7:0] char_code, [15:8] col, [23:16] row, [31:24] count
    input  logic [tcc_pkg::S_TDATA_W-1:0]   s_tdata,
    // [2:0] func
    input  logic [tcc_pkg::FUNC_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] draw_char, [15:8] draw_col, [22:16] draw_row, [23] scrolled,
    // [24] clear_display, [32:25] cursor_col, [39:33] cursor_row, [47:40] read_char
    output logic [tcc_pkg::M_TDATA_W-1:0]   m_tdata,
    // [0] draw_valid
    output logic                            m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tcc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [tcc_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import tcc_pkg::*;

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam logic [ADDR_W-1:0] CELL_LAST  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] MOVE_END   = ADDR_W'(CELLS - COLUMNS);
    localparam logic [COL_W-1:0]  COL_LAST   = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST   = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  COL_LIMIT  = COL_W'(COLUMNS);
    localparam logic [COL_W-1:0]  ROW_LIMIT  = COL_W'(ROWS);

    state_t state_reg, state_next;

    logic [CFG_DATA_W-1:0] fg_color_reg;
    logic [CFG_DATA_W-1:0] bg_color_reg;

    logic [COL_W-1:0]  cur_col_reg;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [ADDR_W-1:0] sweep_reg;
    logic              pend_reg;
    logic [ADDR_W-1:0] pend_addr_reg;

    func_t             func_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [COL_W-1:0]  in_col_reg;
    logic [COL_W-1:0]  in_row_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] addr_reg;

    logic              res_draw_reg;
    logic [CHAR_W-1:0] draw_char_reg;
    logic [COL_W-1:0]  draw_col_reg;
    logic [ROW_W-1:0]  draw_row_reg;
    logic              res_scr_reg;
    logic              res_clr_reg;
    logic [CHAR_W-1:0] res_rd_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CHAR_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CHAR_W-1:0] ram_rdata;

    logic              in_take;
    logic              out_free;
    logic              out_load;
    logic              is_newline;
    logic              is_ignored;
    logic              read_in_range;
    logic              set_in_range;
    logic [COL_W-1:0]  sel_col;
    logic [ROW_W-1:0]  sel_row;
    logic [ADDR_W-1:0] cell_addr;

    tcc_store #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign is_newline    = (char_reg == CH_NEWLINE);
    assign is_ignored    = (char_reg == CH_BACKSPACE) || (char_reg == CH_TAB);
    assign read_in_range = (in_col_reg < COL_LIMIT) && (in_row_reg < ROW_LIMIT);
    assign set_in_range  = read_in_range;

    assign sel_col   = (func_reg == FUNC_READ_CELL) ? in_col_reg : cur_col_reg;
    assign sel_row   = (func_reg == FUNC_READ_CELL) ? in_row_reg[ROW_W-1:0] : cur_row_reg;
    assign cell_addr = ADDR_W'(ADDR_W'(sel_row) * ROW_STRIDE + ADDR_W'(sel_col));

    assign out_free = !m_tvalid_reg || m_tready;
    assign in_take  = s_tvalid && s_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (sweep_reg == CELL_LAST) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_tvalid) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                unique case (func_reg)
                    FUNC_PUT_CHAR: begin
                        if (is_newline) begin
                            state_next = (cur_row_reg == ROW_LAST) ? ST_SCROLL : ST_DONE;
                        end else if (is_ignored) begin
                            state_next = ST_DONE;
                        end else begin
                            state_next = ST_WRITE;
                        end
                    end
                    FUNC_BACKWARD:  state_next = ST_BACK;
                    FUNC_READ_CELL: state_next = read_in_range ? ST_RD : ST_DONE;
                    default:        state_next = ST_DONE;
                endcase
            end
            ST_WRITE: begin
                state_next = (cur_col_reg == COL_LAST && cur_row_reg == ROW_LAST) ?
                             ST_SCROLL : ST_DONE;
            end
            ST_SCROLL: begin
                if (sweep_reg == CELL_LAST) state_next = ST_SCROLL_END;
            end
            ST_SCROLL_END: state_next = ST_DONE;
            ST_BACK: begin
                if (count_reg == '0) state_next = ST_DONE;
            end
            ST_RD:    state_next = ST_RDCAP;
            ST_RDCAP: state_next = ST_DONE;
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // outputs and store port control
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        out_load  = (state_reg == ST_DONE) && out_free;
        ram_raddr = (state_reg == ST_SCROLL) ? sweep_reg : addr_reg;
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = char_reg;
        priority if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = sweep_reg;
            ram_wdata = '0;
        end else if (state_reg == ST_WRITE) begin
            ram_we = 1'b1;
        end else if (pend_reg) begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_reg;
            ram_wdata = ram_rdata;
        end else begin
            ram_we = 1'b0;
        end
    end

    assign cfg_ready = 1'b1;

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            sweep_reg    <= '0;
            pend_reg     <= 1'b0;
            cur_col_reg  <= '0;
            cur_row_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            fg_color_reg <= FG_COLOR_RESET;
            bg_color_reg <= BG_COLOR_RESET;
        end else begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == ST_SCROLL);

            if (cfg_valid && cfg_ready) begin
                if (cfg_addr == CFG_FG_COLOR) fg_color_reg <= cfg_wdata;
                if (cfg_addr == CFG_BG_COLOR) bg_color_reg <= cfg_wdata;
            end

            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR: sweep_reg <= sweep_reg + 1'b1;
                ST_EXEC: begin
                    sweep_reg <= ROW_STRIDE;
                    if (func_reg == FUNC_PUT_CHAR && is_newline) begin
                        cur_col_reg <= '0;
                        if (cur_row_reg != ROW_LAST) cur_row_reg <= cur_row_reg + 1'b1;
                    end
                    if (func_reg == FUNC_SET_CUR && set_in_range) begin
                        cur_col_reg <= in_col_reg;
                        cur_row_reg <= in_row_reg[ROW_W-1:0];
                    end
                end
                ST_WRITE: begin
                    if (cur_col_reg == COL_LAST) begin
                        cur_col_reg <= '0;
                        if (cur_row_reg != ROW_LAST) cur_row_reg <= cur_row_reg + 1'b1;
                    end else begin
                        cur_col_reg <= cur_col_reg + 1'b1;
                    end
                end
                ST_SCROLL: sweep_reg <= sweep_reg + 1'b1;
                ST_BACK: begin
                    if (count_reg != '0) begin
                        if (cur_col_reg == '0) begin
                            cur_col_reg <= COL_LAST;
                            if (cur_row_reg != '0) cur_row_reg <= cur_row_reg - 1'b1;
                        end else begin
                            cur_col_reg <= cur_col_reg - 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // request payload and result fields
    always_ff @(posedge aclk) begin
        pend_addr_reg <= sweep_reg - ROW_STRIDE;

        if (in_take) begin
            func_reg      <= func_t'(s_tuser);
            char_reg      <= s_tdata[7:0];
            in_col_reg    <= s_tdata[15:8];
            in_row_reg    <= s_tdata[23:16];
            count_reg     <= s_tdata[31:24];
            res_draw_reg  <= 1'b0;
            draw_char_reg <= '0;
            draw_col_reg  <= '0;
            draw_row_reg  <= '0;
            res_scr_reg   <= 1'b0;
            res_clr_reg   <= 1'b0;
            res_rd_reg    <= '0;
        end

        unique case (state_reg)
            ST_EXEC: begin
                addr_reg <= cell_addr;
                if (func_reg == FUNC_PUT_CHAR) begin
                    if (is_newline) begin
                        res_scr_reg <= (cur_row_reg == ROW_LAST);
                    end else if (!is_ignored) begin
                        res_draw_reg  <= 1'b1;
                        draw_char_reg <= char_reg;
                        draw_col_reg  <= cur_col_reg;
                        draw_row_reg  <= cur_row_reg;
                    end
                end
                if (func_reg == FUNC_CLEAR) res_clr_reg <= 1'b1;
            end
            ST_WRITE: begin
                res_scr_reg <= (cur_col_reg == COL_LAST) && (cur_row_reg == ROW_LAST);
            end
            ST_BACK: begin
                if (count_reg != '0) count_reg <= count_reg - 1'b1;
            end
            ST_RDCAP: res_rd_reg <= ram_rdata;
            default: ;
        endcase

        if (out_load) begin
            m_tuser_reg <= res_draw_reg;
            m_tdata_reg <= {res_rd_reg, cur_row_reg, cur_col_reg, res_clr_reg, res_scr_reg,
                            draw_row_reg, draw_col_reg, draw_char_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_cursor_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_col_reg <= COL_LAST) && (cur_row_reg <= ROW_LAST))
        else $error("cursor left the screen");

    a_no_write_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        in_take |-> !ram_we)
        else $error("store written while a request is taken");

    a_scroll_on_bottom: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCROLL) |-> (cur_row_reg == ROW_LAST))
        else $error("scroll with cursor above bottom row");

    a_move_dest_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> (pend_addr_reg < MOVE_END))
        else $error("scroll move writes into bottom row");

    a_fg_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> (fg_color_reg == FG_COLOR_RESET && bg_color_reg == BG_COLOR_RESET))
        else $error("color registers not at reset value");
`endif

endmodule

[rtl/tcc_store.sv]
// Character store: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module tcc_store #(
    parameter int DEPTH  = tcc_pkg::DEF_COLUMNS * tcc_pkg::DEF_ROWS,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                        aclk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [tcc_pkg::CHAR_W-1:0]  wdata,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [tcc_pkg::CHAR_W-1:0]  rdata
);
    import tcc_pkg::*;

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
